@@ rtl/lisl_pkg.sv @@
// lisl_pkg: shared constants and command/status types for the longest
// increasing subsequence length block
// no dependencies
package lisl_pkg;

    localparam int unsigned MAX_ELEMENTS = 1024;
    localparam int unsigned VALUE_BITS   = 32;
    localparam int unsigned LEN_BITS     = 11;
    localparam int unsigned ADDR_BITS    = $clog2(MAX_ELEMENTS);
    localparam int unsigned CNT_BITS     = ADDR_BITS + 1;
    localparam int unsigned ENTRY_BITS   = VALUE_BITS + LEN_BITS;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } lisl_cmd_t;

    typedef struct packed {
        logic scan_done;
    } lisl_status_t;

endpackage

@@ rtl/lisl_datapath.sv @@
// lisl_datapath: element store, chain scan, running maximum and result registers
// depends on lisl_pkg
module lisl_datapath
    import lisl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lisl_cmd_t             cmd,
    output lisl_status_t          status,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  last,
    output logic                  done,
    output logic [LEN_BITS-1:0]   lis_length,
    output logic                  overflow
);

    logic [ENTRY_BITS-1:0] mem [MAX_ELEMENTS];

    logic [VALUE_BITS-1:0] key_reg;
    logic                  last_reg;
    logic [LEN_BITS-1:0]   chain_reg;
    logic [LEN_BITS-1:0]   chain_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [LEN_BITS-1:0]   best_reg;
    logic                  ovf_reg;
    logic [CNT_BITS-1:0]   rd_idx_reg;
    logic                  rd_pend_reg;
    logic [ENTRY_BITS-1:0] rd_data_reg;
    logic                  done_reg;
    logic [LEN_BITS-1:0]   len_out_reg;
    logic                  ovf_out_reg;

    logic                  full;
    logic                  rd_en;
    logic [VALUE_BITS-1:0] rd_key;
    logic [LEN_BITS-1:0]   rd_len;
    logic [LEN_BITS-1:0]   rd_len_inc;
    logic [LEN_BITS-1:0]   best_next;

    assign full       = (count_reg == CNT_BITS'(MAX_ELEMENTS));
    assign rd_en      = cmd.scan && !full && (rd_idx_reg < count_reg);
    assign rd_key     = rd_data_reg[ENTRY_BITS-1:LEN_BITS];
    assign rd_len     = rd_data_reg[LEN_BITS-1:0];
    assign rd_len_inc = rd_len + LEN_BITS'(1);

    assign status.scan_done = full || ((rd_idx_reg == count_reg) && !rd_pend_reg);

    always_comb
    begin
        chain_next = chain_reg;
        if (rd_pend_reg && (rd_key < key_reg) && (rd_len_inc > chain_reg))
        begin
            chain_next = rd_len_inc;
        end
    end

    assign best_next = (!full && (chain_reg > best_reg)) ? chain_reg : best_reg;

    // store, with registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx_reg[ADDR_BITS-1:0]];
        end
        if (cmd.commit && !full)
        begin
            mem[count_reg[ADDR_BITS-1:0]] <= {key_reg, chain_reg};
        end
    end

    // request payload, chain accumulator and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= value ^ {1'b1, {(VALUE_BITS-1){1'b0}}};
            last_reg  <= last;
            chain_reg <= LEN_BITS'(1);
        end
        else
        begin
            chain_reg <= chain_next;
        end
        if (cmd.commit)
        begin
            len_out_reg <= best_next;
            ovf_out_reg <= ovf_reg || full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            best_reg    <= '0;
            ovf_reg     <= 1'b0;
            rd_idx_reg  <= '0;
            rd_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= rd_en;
            done_reg    <= cmd.commit && last_reg;
            if (cmd.load)
            begin
                rd_idx_reg <= '0;
            end
            else if (rd_en)
            begin
                rd_idx_reg <= rd_idx_reg + CNT_BITS'(1);
            end
            if (cmd.commit)
            begin
                if (last_reg)
                begin
                    count_reg <= '0;
                    best_reg  <= '0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    best_reg <= best_next;
                    if (full)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg + CNT_BITS'(1);
                    end
                end
            end
        end
    end

    assign done       = done_reg;
    assign lis_length = len_out_reg;
    assign overflow   = ovf_out_reg;

endmodule

@@ rtl/lisl_ctrl.sv @@
// lisl_ctrl: controller state machine sequencing load, scan and commit
// depends on lisl_pkg
module lisl_ctrl
    import lisl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  lisl_status_t status,
    output lisl_cmd_t    cmd,
    output logic         busy
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ rtl/longest_increasing_subsequence_length.sv @@
// Longest strictly increasing subsequence length over a stream of signed values.
// A request is taken when start is high and busy is low. With n (at most 1024) elements
// already stored in the current sequence, busy then stays high while the block makes one
// read of the element store per cycle, waits for the last read to land, spots the end of
// the scan and commits. The next request is taken only once busy is low again. An empty or
// full store skips the reads. A request with last high produces one result on lis_length
// and overflow, marked by done for exactly one cycle, the cycle after the commit. The
// receiver cannot stall it, so it must take the result in that cycle. Requests beyond
// 1024 in a sequence are not stored and set overflow. After a result the block starts a
// fresh sequence.
// depends on lisl_pkg, lisl_ctrl, lisl_datapath
module longest_increasing_subsequence_length
    import lisl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  last,
    output logic                  done,
    output logic [LEN_BITS-1:0]   lis_length,
    output logic                  overflow
);

    lisl_cmd_t    cmd;
    lisl_status_t status;

    lisl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    lisl_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .value      (value),
        .last       (last),
        .done       (done),
        .lis_length (lis_length),
        .overflow   (overflow)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken without going busy");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (lis_length != '0))
        else $error("zero length result");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held");

endmodule

@@ test/lisl_checker.sv @@
// lisl_checker: watches the request and result ports of the longest increasing
// subsequence length block, predicts each result and compares it field by field
// depends on lisl_pkg
`timescale 1ns / 100ps

module lisl_checker
    import lisl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  last,
    input  logic                  done,
    input  logic [LEN_BITS-1:0]   lis_length,
    input  logic                  overflow,
    output int                    mismatches,
    output int                    pending_results
);

    typedef struct packed {
        logic [LEN_BITS-1:0] length;
        logic                overflow;
    } lis_result_t;

    lis_result_t                  expected_lis_q[$];
    logic signed [VALUE_BITS-1:0] seen_values [MAX_ELEMENTS];
    logic [LEN_BITS-1:0]          chain_of [MAX_ELEMENTS];
    int unsigned                  seq_count;
    logic [LEN_BITS-1:0]          longest_chain;
    logic                         store_overflowed;
    int                           fail_total;

    task automatic absorb_element(input logic signed [VALUE_BITS-1:0] elem,
                                  input logic is_last);
        logic [LEN_BITS-1:0] chain;
        lis_result_t         res;
        if (seq_count < MAX_ELEMENTS)
        begin
            chain = LEN_BITS'(1);
            for (int j = 0; j < seq_count; j++)
            begin
                if (seen_values[j] < elem && chain_of[j] + LEN_BITS'(1) > chain)
                    chain = chain_of[j] + LEN_BITS'(1);
            end
            seen_values[seq_count] = elem;
            chain_of[seq_count]    = chain;
            seq_count++;
            if (chain > longest_chain)
                longest_chain = chain;
        end
        else
            store_overflowed = 1'b1;
        if (is_last)
        begin
            res.length       = longest_chain;
            res.overflow     = store_overflowed;
            expected_lis_q.push_back(res);
            seq_count        = 0;
            longest_chain    = '0;
            store_overflowed = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lis_result_t exp_res;
        if (!rst_n)
        begin
            expected_lis_q.delete();
            seq_count        = 0;
            longest_chain    = '0;
            store_overflowed = 1'b0;
            fail_total       = 0;
            mismatches      <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_lis_q.size() == 0)
                begin
                    $display("%0t: unexpected result, lis_length %0d overflow %0b",
                             $time, lis_length, overflow);
                    fail_total++;
                end
                else
                begin
                    exp_res = expected_lis_q.pop_front();
                    if (lis_length !== exp_res.length)
                    begin
                        $display("%0t: lis_length expected %0d actual %0d",
                                 $time, exp_res.length, lis_length);
                        fail_total++;
                    end
                    if (overflow !== exp_res.overflow)
                    begin
                        $display("%0t: overflow expected %0b actual %0b",
                                 $time, exp_res.overflow, overflow);
                        fail_total++;
                    end
                end
            end
            if (start && !busy)
                absorb_element($signed(value), last);
            mismatches      <= fail_total;
            pending_results <= expected_lis_q.size();
        end
    end

endmodule

@@ test/longest_increasing_subsequence_length_test.sv @@
// longest_increasing_subsequence_length_test: drives directed and random
// sequences into the block, including one that overruns the element store
// depends on lisl_pkg, lisl_checker and the block under test
`timescale 1ns / 100ps

module longest_increasing_subsequence_length_test;
    import lisl_pkg::*;

    localparam int CYCLE_LIMIT     = 5_000_000;
    localparam int RANDOM_REQUESTS = 560;
    localparam int DIRECTED_COUNT  = 19;

    localparam logic [VALUE_BITS-1:0] DIRECTED_VALUES [DIRECTED_COUNT] = '{
        32'h8000_0000,
        32'h7fff_ffff,
        32'h8000_0000, 32'h7fff_ffff,
        32'h7fff_ffff, 32'h8000_0000,
        32'd5, 32'd5, 32'd5,
        32'hffff_ffff, 32'd0,
        32'd0, 32'hffff_ffff,
        32'd3, 32'd1, 32'd2, 32'd8, 32'd4, 32'd9
    };
    localparam logic DIRECTED_LAST [DIRECTED_COUNT] = '{
        1'b1,
        1'b1,
        1'b0, 1'b1,
        1'b0, 1'b1,
        1'b0, 1'b0, 1'b1,
        1'b0, 1'b1,
        1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1
    };
    localparam logic [VALUE_BITS-1:0] EDGE_VALUES [7] = '{
        32'h8000_0000, 32'h8000_0001, 32'hffff_ffff, 32'd0,
        32'd1, 32'h7fff_fffe, 32'h7fff_ffff
    };

    typedef enum int {
        STYLE_WIDE,
        STYLE_NARROW,
        STYLE_EDGES,
        STYLE_RISING,
        STYLE_FALLING
    } value_style_t;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [VALUE_BITS-1:0] value = '0;
    logic                  last  = 1'b0;
    logic                  done;
    logic [LEN_BITS-1:0]   lis_length;
    logic                  overflow;
    int                    mismatches;
    int                    pending_results;
    int                    cycle_count;
    int                    requests_sent  = 0;
    int                    sequences_sent = 0;
    logic                  burst = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    longest_increasing_subsequence_length i_dut (.*);

    lisl_checker i_checker (.*);

    task automatic send_request(input logic [VALUE_BITS-1:0] elem, input logic is_last);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 12);
        repeat (gap)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        value <= elem;
        last  <= is_last;
        do
            @(posedge clk);
        while (busy);
        requests_sent++;
        if (is_last)
            sequences_sent++;
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int                    seq_len;
        int                    random_requests;
        value_style_t          style;
        logic [VALUE_BITS-1:0] ramp;
        logic [VALUE_BITS-1:0] elem;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_request(DIRECTED_VALUES[i], DIRECTED_LAST[i]);
        hold_until_drained();

        // rising run fills the store, the larger values after it must be dropped
        for (int i = 0; i < MAX_ELEMENTS + 3; i++)
            send_request(i - 512, i == MAX_ELEMENTS + 2);
        hold_until_drained();

        random_requests = 0;
        while (random_requests < RANDOM_REQUESTS)
        begin
            seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                  : $urandom_range(1, 12);
            style   = value_style_t'($urandom_range(0, 4));
            burst   = ($urandom_range(0, 3) == 0);
            ramp    = $urandom;
            for (int k = 0; k < seq_len; k++)
            begin
                case (style)
                    STYLE_WIDE:    elem = $urandom;
                    STYLE_NARROW:  elem = $urandom_range(0, 8) - 4;
                    STYLE_EDGES:   elem = EDGE_VALUES[$urandom_range(0, 6)];
                    STYLE_RISING:
                    begin
                        ramp = ramp + $urandom_range(0, 3);
                        elem = ramp;
                    end
                    default:
                    begin
                        ramp = ramp - $urandom_range(0, 3);
                        elem = ramp;
                    end
                endcase
                send_request(elem, k == seq_len - 1);
            end
            random_requests += seq_len;
            if ($urandom_range(0, 5) == 0)
                hold_until_drained();
        end
        burst = 1'b0;

        hold_until_drained();
        repeat (MAX_ELEMENTS + 8) @(posedge clk);

        $display("ran %0d requests in %0d sequences: field extremes, equal values,",
                 requests_sent, sequences_sent);
        $display("sign crossings, random runs and one sequence overrunning the store");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lisl_pkg.sv
rtl/lisl_datapath.sv
rtl/lisl_ctrl.sv
rtl/longest_increasing_subsequence_length.sv
test/lisl_checker.sv
test/longest_increasing_subsequence_length_test.sv
